FILE: hdl/egbr_pkg.sv
// Shared types and constants for the Exp-Golomb bitstream reader.
// Used by egbr_ctrl, egbr_datapath and exp_golomb_bitstream_reader; no dependencies.
package egbr_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned FETCH_BYTES = 9;   // enough for 2*31+1 bits past any bit offset
  localparam int unsigned WIN_BITS    = FETCH_BYTES * BYTE_BITS;
  localparam int unsigned CNT_W       = 6;   // bit counts, zero counts, consumed bits
  localparam int unsigned FETCH_W     = 4;
  localparam int unsigned VALUE_W     = 33;
  localparam int unsigned FIXED_MAX   = 32;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_UE    = 2'd2,
    KIND_SE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ALIGN,
    ST_FIXCHK,
    ST_FIXSHIFT,
    ST_PREFIX,
    ST_SUFCHK,
    ST_SUFSHIFT
  } state_e;

  typedef struct packed {
    logic  load;
    logic  start_rd;
    logic  fetch;
    logic  align;
    logic  step;
    logic  zero_seen;
    logic  suffix_init;
    logic  finish_ok;
    logic  finish_err;
    kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic fetch_done;
    logic skip_zero;
    logic fix_bad;
    logic n_zero;
    logic avail_zero;
    logic head_bit;
    logic z_at_max;
    logic suffix_short;
  } sts_t;

endpackage

FILE: hdl/egbr_ctrl.sv
// Controller state machine of the Exp-Golomb bitstream reader.
// Depends on egbr_pkg; drives egbr_datapath through cmd_t, watches sts_t.
module egbr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      kind_i,
  output logic            busy_o,
  output egbr_pkg::cmd_t  cmd_o,
  input  egbr_pkg::sts_t  sts_i
);
  import egbr_pkg::*;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_LOAD;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.kind = kind_q;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (kind_e'(kind_i) == KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start_rd = 1'b1;
            kind_d  = kind_e'(kind_i);
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (sts_i.fetch_done) begin
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // drop the bits ahead of the cursor inside the first byte
        if (sts_i.skip_zero) begin
          state_d = (kind_q == KIND_FIXED) ? ST_FIXCHK : ST_PREFIX;
        end else begin
          cmd_o.align = 1'b1;
        end
      end
      ST_FIXCHK: begin
        if (sts_i.fix_bad) begin
          cmd_o.finish_err = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FIXSHIFT;
        end
      end
      ST_PREFIX: begin
        if (sts_i.avail_zero) begin
          cmd_o.finish_err = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.head_bit) begin
          cmd_o.step = 1'b1;
          state_d = ST_SUFCHK;
        end else if (sts_i.z_at_max) begin
          cmd_o.finish_err = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.step      = 1'b1;
          cmd_o.zero_seen = 1'b1;
        end
      end
      ST_SUFCHK: begin
        if (sts_i.suffix_short) begin
          cmd_o.finish_err = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.suffix_init = 1'b1;
          state_d = ST_SUFSHIFT;
        end
      end
      ST_FIXSHIFT, ST_SUFSHIFT: begin
        if (sts_i.n_zero) begin
          cmd_o.finish_ok = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/egbr_datapath.sv
// Datapath of the Exp-Golomb bitstream reader: byte buffer, cursor, bit window,
// counters and result register. Depends on egbr_pkg; commanded by egbr_ctrl.
module egbr_datapath #(
  parameter int unsigned BUFFER_BYTES      = 4096,
  parameter int unsigned MAX_LEADING_ZEROS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  egbr_pkg::cmd_t        cmd_i,
  output egbr_pkg::sts_t        sts_o,
  input  logic [7:0]            byte_value_i,
  input  logic [5:0]            bit_count_i,
  output logic                  valid_o,
  output logic signed [32:0]    value_o,
  output logic                  error_o
);
  import egbr_pkg::*;

  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned LW = AW + 1;   // byte counts up to the depth itself
  localparam int unsigned CW = LW + 3;   // cursor and counts in bits

  logic [7:0]            mem_q [BUFFER_BYTES];
  logic [7:0]            rdata_q;
  logic                  rvalid_q;
  logic [LW-1:0]         loaded_q;
  logic [CW-1:0]         cur_q, cur_d;
  logic [FETCH_W-1:0]    fetch_q;
  logic [WIN_BITS-1:0]   win_q;
  logic [2:0]            skip_q;
  logic [CW-1:0]         avail_q;
  logic [CNT_W-1:0]      cons_q;
  logic [CNT_W-1:0]      n_q;
  logic [CNT_W-1:0]      z_q;
  logic [CNT_W-1:0]      bitcnt_q;
  logic [VALUE_W-1:0]    acc_q;
  logic                  valid_q;
  logic                  error_q;
  logic [VALUE_W-1:0]    value_q, value_d;

  logic [LW-1:0]         rd_pos;
  logic [AW-1:0]         rd_addr;
  logic [CW-1:0]         total_bits;
  logic                  full;
  logic                  issue;
  logic [VALUE_W-1:0]    half;

  assign full       = (loaded_q == LW'(BUFFER_BYTES));
  assign total_bits = {loaded_q, 3'b000};
  assign rd_pos     = cur_q[CW-1:3] + LW'(fetch_q);
  assign rd_addr    = rd_pos[AW-1:0];
  assign issue      = cmd_i.fetch && (fetch_q != FETCH_W'(FETCH_BYTES));
  assign cur_d      = cur_q + CW'(cons_q);

  // byte buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[loaded_q[AW-1:0]] <= byte_value_i;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      cur_q    <= '0;
      fetch_q  <= '0;
      rvalid_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load && !full) begin
        loaded_q <= loaded_q + LW'(1);
      end
      if (cmd_i.start_rd) begin
        fetch_q <= '0;
      end else if (issue) begin
        fetch_q <= fetch_q + FETCH_W'(1);
      end
      rvalid_q <= issue;
      if (cmd_i.finish_ok) begin
        cur_q <= cur_d;
      end
      valid_q <= cmd_i.finish_ok || cmd_i.finish_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_rd) begin
      skip_q   <= cur_q[2:0];
      avail_q  <= total_bits - cur_q;
      cons_q   <= '0;
      n_q      <= bit_count_i;
      bitcnt_q <= bit_count_i;
      z_q      <= '0;
      acc_q    <= '0;
    end else begin
      if (cmd_i.align) begin
        skip_q <= skip_q - 3'd1;
      end
      if (cmd_i.step) begin
        avail_q <= avail_q - CW'(1);
        cons_q  <= cons_q + CNT_W'(1);
        acc_q   <= {acc_q[VALUE_W-2:0], win_q[WIN_BITS-1]};
        if (n_q != '0) begin
          n_q <= n_q - CNT_W'(1);
        end
      end
      if (cmd_i.zero_seen) begin
        z_q <= z_q + CNT_W'(1);
      end
      // leading one of the code: acc holds 2^z + suffix; ue subtracts one at the end
      if (cmd_i.suffix_init) begin
        acc_q <= VALUE_W'(1);
        n_q   <= z_q;
      end
    end
    if (rvalid_q) begin
      win_q <= {win_q[WIN_BITS-BYTE_BITS-1:0], rdata_q};
    end else if (cmd_i.align || cmd_i.step) begin
      win_q <= {win_q[WIN_BITS-2:0], 1'b0};
    end
    if (cmd_i.finish_ok || cmd_i.finish_err) begin
      error_q <= cmd_i.finish_err;
      value_q <= cmd_i.finish_ok ? value_d : '0;
    end
  end

  // map the collected code to the result
  always_comb begin
    half = {1'b0, acc_q[VALUE_W-1:1]};
    case (cmd_i.kind)
      KIND_UE:    value_d = acc_q - VALUE_W'(1);
      KIND_SE:    value_d = acc_q[0] ? (VALUE_W'(0) - half) : half;
      default:    value_d = acc_q;
    endcase
  end

  always_comb begin
    sts_o.fetch_done   = (fetch_q == FETCH_W'(FETCH_BYTES)) && !rvalid_q;
    sts_o.skip_zero    = (skip_q == 3'd0);
    sts_o.fix_bad      = (bitcnt_q > CNT_W'(FIXED_MAX)) || (avail_q < CW'(bitcnt_q));
    sts_o.n_zero       = (n_q == '0);
    sts_o.avail_zero   = (avail_q == '0);
    sts_o.head_bit     = win_q[WIN_BITS-1];
    sts_o.z_at_max     = (z_q == CNT_W'(MAX_LEADING_ZEROS));
    sts_o.suffix_short = (avail_q < CW'(z_q));
  end

  assign valid_o = valid_q;
  assign value_o = $signed(value_q);
  assign error_o = error_q;

endmodule

FILE: hdl/exp_golomb_bitstream_reader.sv
// Exp-Golomb bitstream reader: loads may come back to back and fill the buffer up to its depth.
// A read item raises valid_o once nine single-byte fetches, the skip of the bit offset and a
// one-bit shifter over the consumed bits are through; an error ends the item sooner.
// busy is high until the cycle of the result, when the next item may already be accepted.
// Reset (asynchronous, active low) empties the buffer and puts the cursor at bit zero.
// Depends on egbr_pkg, egbr_ctrl and egbr_datapath.
module exp_golomb_bitstream_reader #(
  parameter int unsigned BUFFER_BYTES      = 4096,
  parameter int unsigned MAX_LEADING_ZEROS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         byte_value_i,
  input  logic [5:0]         bit_count_i,
  output logic               valid_o,
  output logic signed [32:0] value_o,
  output logic               error_o
);
  import egbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  egbr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  egbr_datapath #(
    .BUFFER_BYTES      (BUFFER_BYTES),
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .byte_value_i (byte_value_i),
    .bit_count_i  (bit_count_i),
    .valid_o      (valid_o),
    .value_o      (value_o),
    .error_o      (error_o)
  );

endmodule
